// ===== hw/rtl/lbphe_pkg.sv =====
// ---------------------------------------------------------------------------
// lbphe_pkg
// Shared types and constants of the LBP histogram engine.
// ---------------------------------------------------------------------------
`default_nettype none

package lbphe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int NUM_BINS   = 256;

  localparam int PIX_W   = 8;
  localparam int BIN_W   = 8;
  localparam int DIM_W   = 11;
  localparam int CNT_W   = 21;
  localparam int FRAC_W  = 17;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT) + 1;
  localparam int QDEPTH  = 4;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int DIV_STEPS = 16;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(65536);
  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(256);

  // Neighbor offsets in the 3x3 window, clockwise from top-left.
  localparam logic [1:0] NY [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1};
  localparam logic [1:0] NX [8] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_READ  = 2'd1,
    MODE_START = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_PIX   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e             kind;
    logic                 bump0;    // count into bin 0 (border pixel)
    logic                 code_en;  // count the pattern code
    logic [BIN_W-1:0]     bin;      // pattern code or selected bin
    logic                 done;     // frame complete at read time
    logic [CNT_W-1:0]     total;    // width times height
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbphe_queue.sv =====
// ---------------------------------------------------------------------------
// lbphe_queue
// Short FIFO of operations between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module lbphe_queue
  import lbphe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output op_t       pop_op_o,
  output logic      empty_o
);

  op_t                entry_q [QDEPTH];
  logic [QIDX_W-1:0]  wr_q, rd_q;
  logic [QIDX_W:0]    cnt_q;

  assign full_o   = (cnt_q == (QIDX_W+1)'(QDEPTH));
  assign empty_o  = (cnt_q == '0);
  assign pop_op_o = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entry_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbphe_front.sv =====
// ---------------------------------------------------------------------------
// lbphe_front
// Accept items, run line stores and window, form LBP codes, issue operations.
// ---------------------------------------------------------------------------
`default_nettype none

module lbphe_front
  import lbphe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [DIM_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic [BIN_W-1:0] bin_select_i,
  output logic                  push_o,
  output op_t                   push_op_o,
  input  wire logic             full_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_PIX  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q;

  logic [DIM_W-1:0] width_q, height_q, eff_w, eff_h;
  logic [CNT_W-1:0] total, pix_cnt_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PIX_W-1:0] px_q, up_q, lo_q;
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] nwin  [3][3];
  logic [BIN_W-1:0] code;
  logic             border, code_en, last_col, accept, full_frame;
  op_t              op_q;

  // Clamp geometry to 1..MAX.
  always_comb begin
    eff_w = width_q;
    if (width_q == '0) eff_w = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = height_q;
    if (height_q == '0) eff_h = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
  end

  assign total      = CNT_W'(eff_w) * CNT_W'(eff_h);
  assign full_frame = (pix_cnt_q >= total);
  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == F_PUSH);
  assign push_op_o  = op_q;

  // Window after the new column shifts in.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nwin[i][0] = win_q[i][1];
      nwin[i][1] = win_q[i][2];
    end
    nwin[0][2] = up_q;
    nwin[1][2] = lo_q;
    nwin[2][2] = px_q;
    for (int b = 0; b < 8; b++) begin
      code[b] = (nwin[NY[b]][NX[b]] >= nwin[1][1]);
    end
  end

  assign last_col = ({1'b0, col_q} + 1'b1 >= eff_w);
  assign border   = (row_q == '0) ||
                    (({1'b0, row_q} + 1'b1) >= (ROW_W+1)'(eff_h)) ||
                    (col_q == '0) || last_col;
  assign code_en  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
                    (row_q < ROW_W'(eff_h)) && ({1'b0, col_q} < eff_w);

  // Line stores: registered read at accept, write-back on the next cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q <= upper_mem[col_q];
      lo_q <= lower_mem[col_q];
      px_q <= pixel_i;
    end
    if (state_q == F_PIX) begin
      upper_mem[col_q] <= lo_q;
      lower_mem[col_q] <= px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
      col_q     <= '0;
      row_q     <= '0;
      pix_cnt_q <= '0;
      op_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default:    ;
        endcase
      end
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            op_q.total <= total;
            op_q.done  <= full_frame;
            op_q.bin   <= bin_select_i;
            unique case (mode_e'(mode_i))
              MODE_PIXEL: begin
                if (!full_frame) state_q <= F_PIX;
              end
              MODE_READ: begin
                op_q.kind <= OP_READ;
                state_q   <= F_PUSH;
              end
              MODE_START: begin
                op_q.kind <= OP_CLEAR;
                col_q     <= '0;
                row_q     <= '0;
                pix_cnt_q <= '0;
                for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
                end
                state_q   <= F_PUSH;
              end
              default: ;
            endcase
          end
        end
        F_PIX: begin
          win_q        <= nwin;
          op_q.kind    <= OP_PIX;
          op_q.bump0   <= border;
          op_q.code_en <= code_en;
          op_q.bin     <= code;
          pix_cnt_q    <= pix_cnt_q + 1'b1;
          if (last_col) begin
            col_q <= '0;
            // Hold the row at its ceiling; every compare stays right there.
            if (row_q != '1) row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
          // Drop interior pixels that complete no pattern.
          state_q <= (border || code_en) ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbphe_back.sv =====
// ---------------------------------------------------------------------------
// lbphe_back
// Histogram store with read-modify-write, bin read-out and Q1.16 divider.
// ---------------------------------------------------------------------------
`default_nettype none

module lbphe_back
  import lbphe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  output logic                   pop_o,
  input  wire op_t               pop_op_i,
  input  wire logic              empty_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BIN_W-1:0]       bin_number_o,
  output logic [CNT_W-1:0]       bin_count_o,
  output logic [FRAC_W-1:0]      bin_fraction_o,
  output logic                   frame_complete_o
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_ISSUE = 5'b00010,
    B_DATA  = 5'b00100,
    B_DIV   = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_e;

  bstate_e state_q;
  op_t              op_q;
  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rd_q, cnt_q, rem_q, value;
  logic [NUM_BINS-1:0] vld_q;
  logic [BIN_W-1:0] addr_q;
  logic [FRAC_W-1:0] quo_q;
  logic [4:0]       step_q;
  logic [CNT_W:0]   rem2;
  logic             rem_ge, wr_en, out_load;
  logic [CNT_W-1:0] wr_val;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign value    = vld_q[addr_q] ? rd_q : '0;
  assign wr_en    = (state_q == B_DATA) && (op_q.kind == OP_PIX);
  assign wr_val   = (value == COUNT_MAX) ? value : value + 1'b1;
  assign rem2     = {rem_q, 1'b0};
  assign rem_ge   = (rem2 >= {1'b0, op_q.total});
  assign out_load = (state_q == B_OUT) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (state_q == B_ISSUE) rd_q <= mem[addr_q];
    if (wr_en) mem[addr_q] <= wr_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= B_IDLE;
      vld_q            <= '0;
      op_q             <= '0;
      addr_q           <= '0;
      cnt_q            <= '0;
      rem_q            <= '0;
      quo_q            <= '0;
      step_q           <= '0;
      out_valid_o      <= 1'b0;
      bin_number_o     <= '0;
      bin_count_o      <= '0;
      bin_fraction_o   <= '0;
      frame_complete_o <= 1'b0;
    end else begin
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            op_q <= pop_op_i;
            if (pop_op_i.kind == OP_CLEAR) begin
              vld_q <= '0;
            end else begin
              addr_q  <= (pop_op_i.kind == OP_PIX && pop_op_i.bump0) ? '0 : pop_op_i.bin;
              state_q <= B_ISSUE;
            end
          end
        end
        B_ISSUE: state_q <= B_DATA;
        B_DATA: begin
          if (op_q.kind == OP_PIX) begin
            vld_q[addr_q] <= 1'b1;
            if (op_q.bump0 && op_q.code_en) begin
              op_q.bump0 <= 1'b0;
              addr_q     <= op_q.bin;
              state_q    <= B_ISSUE;
            end else begin
              state_q <= B_IDLE;
            end
          end else begin
            cnt_q  <= value;
            rem_q  <= value;
            step_q <= '0;
            if (value >= op_q.total) begin
              quo_q   <= FRAC_ONE;
              state_q <= B_OUT;
            end else begin
              quo_q   <= '0;
              state_q <= B_DIV;
            end
          end
        end
        B_DIV: begin
          // One quotient bit per cycle, restoring.
          rem_q  <= rem_ge ? CNT_W'(rem2 - {1'b0, op_q.total}) : rem2[CNT_W-1:0];
          quo_q  <= {quo_q[FRAC_W-2:0], rem_ge};
          step_q <= step_q + 1'b1;
          if (step_q == 5'(DIV_STEPS - 1)) state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            bin_number_o     <= addr_q;
            bin_count_o      <= cnt_q;
            bin_fraction_o   <= quo_q;
            frame_complete_o <= op_q.done;
            state_q          <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_histogram_engine_top.sv =====
// ---------------------------------------------------------------------------
// lbp_histogram_engine_top
// Streaming 8-neighbor LBP histogram engine with bin read-out.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------
//   in       | input     | in_valid_i / in_ready_o   | mode_i, pixel_i,
//            |           |                           | bin_select_i
//   out      | output    | out_valid_o / out_ready_i | bin_number_o, bin_count_o,
//            |           |                           | bin_fraction_o,
//            |           |                           | frame_complete_o
//   cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// A pixel beat passes through the front as line store read, window update and
// queue push, with no push when it counts into no bin. The back pops, reads
// and writes back for each histogram update, and makes a second update for a
// border pixel that also completes a pattern. A read beat is popped, read and
// loaded to the output by the back, passing the divider first when the count
// is below width times height.
// Reset clears the histogram (per-bin valid bits), positions and window at
// once; line stores are not cleared. The front stalls only on a full queue,
// the back only on an unread result.
// ---------------------------------------------------------------------------
`default_nettype none

module lbp_histogram_engine_top
  import lbphe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [DIM_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [PIX_W-1:0]  pixel_i,
  input  wire logic [BIN_W-1:0]  bin_select_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BIN_W-1:0]       bin_number_o,
  output logic [CNT_W-1:0]       bin_count_o,
  output logic [FRAC_W-1:0]      bin_fraction_o,
  output logic                   frame_complete_o
);

  // Operations travel from front to back through the queue.
  logic push, full, pop, empty;
  op_t  push_op, pop_op;

  lbphe_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .pixel_i, .bin_select_i,
    .push_o(push), .push_op_o(push_op), .full_i(full)
  );

  lbphe_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_op_i(push_op), .full_o(full),
    .pop_i(pop), .pop_op_o(pop_op), .empty_o(empty)
  );

  lbphe_back u_back (
    .clk_i, .rst_ni,
    .pop_o(pop), .pop_op_i(pop_op), .empty_i(empty),
    .out_valid_o, .out_ready_i, .bin_number_o, .bin_count_o,
    .bin_fraction_o, .frame_complete_o
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lbphe_checker.sv =====
// ---------------------------------------------------------------------------
// lbphe_checker
// Port-level assertions for the LBP histogram engine, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module lbphe_checker
  import lbphe_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        mode_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CNT_W-1:0]  bin_count_o,
  input wire logic [FRAC_W-1:0] bin_fraction_o
);

  // A stalled result beat holds its count.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_count_o))
    else $error("result beat dropped or changed while stalled");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bin_fraction_o <= FRAC_ONE)
    else $error("fraction above one");

  a_zero_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_count_o == '0 |-> bin_fraction_o == '0)
    else $error("empty bin with nonzero fraction");

  // A read or start beat always occupies the front for a push.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_READ || mode_i == MODE_START)
    |=> !in_ready_o)
    else $error("input taken while previous beat in flight");

endmodule

bind lbp_histogram_engine_top lbphe_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .out_valid_o, .out_ready_i,
  .bin_count_o, .bin_fraction_o
);

`default_nettype wire
